// File: design/terrain_polyline_collision_macros.svh
// Assertion macros shared by the checkers of the terrain collision block.
// Every macro expects signals named clk and rst in the scope where it is used.
`ifndef TERRAIN_POLYLINE_COLLISION_MACROS_SVH
`define TERRAIN_POLYLINE_COLLISION_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TPC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tpc_pkg.sv
// Package of the terrain collision block: field widths, beat structs, register
// indexes, command codes and the sequencer state type. No dependencies.
package tpc_pkg;

  localparam int COORD_W     = 14;
  localparam int QUERY_W     = 18;
  localparam int HALF_W      = 14;
  localparam int INDEX_W     = 6;
  localparam int HEIGHT_W    = 18;
  localparam int MAP_W       = 14;
  localparam int PCOUNT_W    = 7;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_INDEX_W = 2;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 4;
  localparam int MIN_POINTS     = 2;
  localparam int HEIGHT_MAX     = 262143;
  localparam int DIV_BITS       = 2;

  localparam logic [MAP_W-1:0]    MAP_WIDTH_RST   = MAP_W'(1000);
  localparam logic [MAP_W-1:0]    MAP_HEIGHT_RST  = MAP_W'(1000);
  localparam logic [PCOUNT_W-1:0] POINT_COUNT_RST = '0;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_WIDTH   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_HEIGHT  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_COUNT = CFG_INDEX_W'(2);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [INDEX_W-1:0]  point_index;
    logic [COORD_W-1:0]  point_x;
    logic [COORD_W-1:0]  point_y;
    logic [QUERY_W-1:0]  query_x;
    logic [QUERY_W-1:0]  query_y;
    logic [HALF_W-1:0]   half_size;
  } item_t;

  typedef struct packed {
    logic                on_map;
    logic                segment_found;
    logic                collides;
    logic [HEIGHT_W-1:0] terrain_height;
    logic [INDEX_W-1:0]  segment_index;
  } result_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } bp_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

endpackage

// File: design/tpc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the breakpoint table; no package dependency.
module tpc_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/tpc_div.sv
// Serial signed divider, truncating toward zero, DIV_BITS quotient bits per cycle.
// Depends on tpc_pkg for the radix.
module tpc_div #(
  parameter int NW = 34,
  parameter int DW = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);
  import tpc_pkg::*;

  localparam int STEPS = (NW + DIV_BITS - 1) / DIV_BITS;
  localparam int PADW  = STEPS * DIV_BITS;
  localparam int CNTW  = $clog2(STEPS + 1);

  logic            active;
  logic [CNTW-1:0] cnt;
  logic            neg;
  logic [DW-1:0]   den_mag;
  logic [DW-1:0]   rem;
  logic [PADW-1:0] dvd;
  logic [PADW-1:0] q;
  logic [DW-1:0]   rem_next;
  logic [PADW-1:0] dvd_next;
  logic [PADW-1:0] q_next;
  logic [NW-1:0]   num_mag;
  logic [DW-1:0]   den_mag_in;

  assign num_mag    = num[NW-1] ? (~num + 1'b1) : num;
  assign den_mag_in = den[DW-1] ? (~den + 1'b1) : den;

  // Restoring division: each pass shifts one dividend bit into the partial
  // remainder and subtracts the divisor when it fits.
  always_comb begin
    logic [DW:0] trial;
    rem_next = rem;
    dvd_next = dvd;
    q_next   = q;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial    = {rem_next, dvd_next[PADW-1]};
      dvd_next = dvd_next << 1;
      if (trial >= {1'b0, den_mag}) begin
        rem_next = DW'(trial - {1'b0, den_mag});
        q_next   = {q_next[PADW-2:0], 1'b1};
      end else begin
        rem_next = DW'(trial);
        q_next   = {q_next[PADW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNTW'(STEPS);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg     <= num[NW-1] ^ den[DW-1];
      den_mag <= den_mag_in;
      rem     <= '0;
      dvd     <= PADW'(num_mag);
      q       <= '0;
    end else if (active) begin
      rem <= rem_next;
      dvd <= dvd_next;
      q   <= q_next;
    end
  end

  assign quo = $signed(NW'(neg ? (~q + 1'b1) : q));

endmodule

// File: design/terrain_polyline_collision.sv
// Top level of the terrain collision block: breakpoint table RAM, scan and
// interpolation sequencer, configuration registers. Uses tpc_pkg, tpc_ram, tpc_div.
//
// The block keeps a table of terrain breakpoints (x, height) in a RAM and answers
// hitbox queries against the polyline they form. An item is taken when start is
// high and busy is low; every item yields exactly one result beat, shown on result
// for a single cycle with done high, and the receiver cannot hold it off, so it
// must capture the beat in that cycle. A write item (cmd 0) stores its breakpoint
// at the taking edge and its all-zero result beat follows in the next cycle, with
// busy staying low. A query whose point is off the map, or that finds fewer than
// two breakpoints, also answers in the next cycle. Any other query walks the table
// from entry 0, one RAM read per cycle, until the first breakpoint whose x lies
// past the query x. A hit then takes a step for the multiply, one to start the
// divider, the serial division (PW is the product width, 34 bits with four
// fraction bits) and a step to saturate and compare; a segment of zero width skips
// the divider. A walk that finds no segment ends at the last table entry that
// point_count covers. The next item may be taken in the cycle that carries the
// result beat. The divider and the single RAM read port set the pace of a query.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// make such writes only while the block is idle, which the block itself does not
// enforce. Indexes past the last register are ignored. Table entries come out of
// reset undefined and must be written before a query reaches them.
module terrain_polyline_collision #(
  parameter int MAX_POINTS = tpc_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = tpc_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  tpc_pkg::item_t                   item,
  input  logic                             cfg_we,
  input  logic [tpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             done,
  output tpc_pkg::result_t                 result
);
  import tpc_pkg::*;

  // Table address width and a counter wide enough to hold the table depth.
  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  // Width of a whole-unit coordinate once scaled to fixed point.
  localparam int SW  = COORD_W + FRAC_BITS;
  // Unsigned compare width for query x against scaled map and breakpoint x.
  localparam int UW  = (QUERY_W > SW) ? QUERY_W : SW;
  // Signed widths: x offset, segment deltas, product, and the height sum.
  localparam int SXW = UW + 1;
  localparam int DW  = COORD_W + 1;
  localparam int PW  = SXW + DW;
  localparam int HW  = PW + 1;
  localparam int BW  = QUERY_W + 2;

  // Configuration registers.
  logic [MAP_W-1:0]    map_width;
  logic [MAP_W-1:0]    map_height;
  logic [PCOUNT_W-1:0] point_count;

  // Sequencer.
  state_t state;
  state_t state_next;

  // Query context, captured when the item is taken, and the walk state.
  logic [QUERY_W-1:0] qx;
  logic [QUERY_W-1:0] qy;
  logic [HALF_W-1:0]  half;
  logic [CW-1:0]      count;
  logic [AW-1:0]      chk_idx;
  logic [AW-1:0]      seg;
  bp_entry_t          prev;
  bp_entry_t          lo_pt;
  bp_entry_t          hi_pt;

  // Arithmetic pipeline registers.
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] den;
  logic                 d_zero;

  // RAM and divider hookups.
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  bp_entry_t                   ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [$bits(bp_entry_t)-1:0] ram_rdata;
  bp_entry_t                   rd_pt;
  logic                        div_start;
  logic                        div_done;
  logic signed [PW-1:0]        div_quo;

  // Combinational helpers.
  logic                 accept;
  logic                 q_on_map;
  logic [CW-1:0]        count_lim;
  logic                 hit;
  logic                 last;
  logic signed [SXW-1:0] dx;
  logic signed [DW-1:0]  dy;
  logic signed [DW-1:0]  dxb;
  logic signed [PW-1:0]  quo_eff;
  logic signed [HW-1:0]  h_raw;
  logic [HEIGHT_W-1:0]   h_sat;
  logic signed [BW-1:0]  bottom;
  logic                  done_next;
  result_t               result_next;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // The query point must lie strictly inside the map in both axes.
  assign q_on_map = (item.query_x != '0) && (item.query_y != '0) &&
                    (UW'(item.query_x) < (UW'(map_width) << FRAC_BITS)) &&
                    (UW'(item.query_y) < (UW'(map_height) << FRAC_BITS));

  // A point count past the table depth acts as the full table.
  assign count_lim = (32'(point_count) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                         : CW'(point_count);

  // Table writes happen at the taking edge; slots past the table are dropped.
  assign ram_we    = accept && (item.cmd == CMD_WRITE) &&
                     (32'(item.point_index) < 32'(MAX_POINTS));
  assign ram_waddr = AW'(item.point_index);
  assign ram_wdata = '{x: item.point_x, y: item.point_y};

  tpc_ram #(
    .WIDTH ($bits(bp_entry_t)),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_pt = bp_entry_t'(ram_rdata);

  // During the walk rd_pt is entry chk_idx. Entry 0 only seeds the lower end.
  assign hit  = (chk_idx != '0) && ((UW'(rd_pt.x) << FRAC_BITS) > UW'(qx));
  assign last = ((CW'(chk_idx) + CW'(1)) == count);

  // Segment deltas for the multiply stage.
  assign dx  = $signed(SXW'(qx)) - $signed(SXW'(lo_pt.x) << FRAC_BITS);
  assign dy  = $signed(DW'(hi_pt.y)) - $signed(DW'(lo_pt.y));
  assign dxb = $signed(DW'(hi_pt.x)) - $signed(DW'(lo_pt.x));

  tpc_div #(
    .NW (PW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // A segment of zero width keeps the lower breakpoint's height.
  assign quo_eff = d_zero ? '0 : div_quo;
  assign h_raw   = $signed(HW'(lo_pt.y) << FRAC_BITS) + HW'(quo_eff);

  always_comb begin
    if (h_raw < 0) begin
      h_sat = '0;
    end else if (h_raw > $signed(HW'(HEIGHT_MAX))) begin
      h_sat = HEIGHT_W'(HEIGHT_MAX);
    end else begin
      h_sat = HEIGHT_W'(h_raw);
    end
  end

  // Hitbox bottom, signed, so a half size above the query y still compares.
  assign bottom = $signed(BW'(qy)) - $signed(BW'(half));

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width   <= MAP_WIDTH_RST;
      map_height  <= MAP_HEIGHT_RST;
      point_count <= POINT_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_WIDTH:   map_width   <= MAP_W'(cfg_data);
        CFG_MAP_HEIGHT:  map_height  <= MAP_W'(cfg_data);
        CFG_POINT_COUNT: point_count <= cfg_data[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Next state, RAM reads, divider start and the result beat.
  always_comb begin
    state_next  = state;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    div_start   = 1'b0;
    done_next   = 1'b0;
    result_next = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((item.cmd == CMD_QUERY) && q_on_map && (count_lim >= CW'(MIN_POINTS))) begin
            ram_re     = 1'b1;
            state_next = ST_SCAN;
          end else begin
            done_next          = 1'b1;
            result_next.on_map = (item.cmd == CMD_QUERY) && q_on_map;
          end
        end
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = chk_idx + 1'b1;
        if (hit) begin
          state_next = ST_MUL;
        end else if (last) begin
          state_next         = ST_IDLE;
          done_next          = 1'b1;
          result_next.on_map = 1'b1;
        end
      end
      ST_MUL: begin
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start  = !d_zero;
        state_next = d_zero ? ST_FINISH : ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next                 = ST_IDLE;
        done_next                  = 1'b1;
        result_next.on_map         = 1'b1;
        result_next.segment_found  = 1'b1;
        result_next.collides       = (bottom <= $signed(BW'(h_sat)));
        result_next.terrain_height = h_sat;
        result_next.segment_index  = INDEX_W'(seg);
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath registers; none of them needs a reset.
  always_ff @(posedge clk) begin
    if (done_next) begin
      result <= result_next;
    end
    case (state)
      ST_IDLE: begin
        if (accept) begin
          qx      <= item.query_x;
          qy      <= item.query_y;
          half    <= item.half_size;
          count   <= count_lim;
          chk_idx <= '0;
        end
      end
      ST_SCAN: begin
        prev    <= rd_pt;
        chk_idx <= chk_idx + 1'b1;
        if (hit) begin
          lo_pt <= prev;
          hi_pt <= rd_pt;
          seg   <= chk_idx - 1'b1;
        end
      end
      ST_MUL: begin
        prod   <= PW'(dy) * PW'(dx);
        den    <= dxb;
        d_zero <= (hi_pt.x == lo_pt.x);
      end
      default: ;
    endcase
  end

endmodule

// File: design/tpc_checker.sv
// Port-level checker for the terrain collision block, bound to the top level.
// Uses tpc_pkg for the result type and the shared assertion macros header.
`include "terrain_polyline_collision_macros.svh"

module tpc_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input tpc_pkg::result_t result
);
  import tpc_pkg::*;

  // A taken item either answers at once or keeps the block busy.
  `TPC_ASSERT_NEXT(a_item_progresses, start && !busy, done || busy, "taken item neither answered nor busy")

  // An off-map query carries nothing but zeros.
  `TPC_ASSERT(a_off_map_clean, done && !result.on_map, !result.segment_found && !result.collides && result.terrain_height == '0 && result.segment_index == '0, "off-map beat carries data")

  // Without a segment there is no height, no index and no collision.
  `TPC_ASSERT(a_no_segment_clean, done && !result.segment_found, !result.collides && result.terrain_height == '0 && result.segment_index == '0, "segment-less beat carries data")

  // Finishing a query always delivers its beat.
  `TPC_ASSERT(a_finish_gives_beat, !$past(rst) && $fell(busy), done, "busy dropped without a result beat")

  // A beat only follows a taken item or work in progress.
  `TPC_ASSERT(a_no_spurious_beat, done, $past(start && !busy) || $past(busy), "result beat without work")

endmodule

bind terrain_polyline_collision tpc_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
